FILE: hw/rtl/sat_pkg.sv
// Shared constants, types and address helpers for the summed-area table.
// Used by sat_build, summed_area_table and sat_checker; no dependencies.
`default_nettype none
package sat_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int PSTRIDE    = MAX_COLS + 1;
  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int PFX_DEPTH  = (MAX_ROWS + 1) * (MAX_COLS + 1);
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int PFX_AW     = $clog2(PFX_DEPTH);

  localparam int DATA_W     = 32;
  localparam int COORD_W    = 7;
  localparam int DIM_W      = 7;
  localparam int OP_W       = 2;
  localparam int CFG_IW     = 8;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam int DIM_RESET_H = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int DIM_RESET_W = (MAX_COLS < 64) ? MAX_COLS : 64;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 8'd0;
  localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 8'd1;

  typedef struct packed {
    logic              en;
    logic [PFX_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } pfx_wr_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
    int a;
    a = int'(r) * MAX_COLS + int'(c);
    return CELL_AW'(a);
  endfunction

  function automatic logic [PFX_AW-1:0] pfx_addr(input logic [COORD_W-1:0] i,
                                                 input logic [COORD_W-1:0] j);
    int a;
    a = int'(i) * PSTRIDE + int'(j);
    return PFX_AW'(a);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sat_build.sv
// Prefix table build sequencer: walks rows and columns, reads cell and upper
// prefix entry, keeps a running row sum and writes each prefix entry. Uses sat_pkg.
`default_nettype none
module sat_build
  import sat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIM_W-1:0]   grid_height,
  input  wire logic [DIM_W-1:0]   grid_width,
  input  wire logic [DATA_W-1:0]  cell_rd_data,
  input  wire logic [DATA_W-1:0]  pfx_rd_data,
  output logic      [CELL_AW-1:0] cell_rd_addr,
  output logic      [PFX_AW-1:0]  pfx_rd_addr,
  output pfx_wr_t                 pfx_wr,
  output logic                    done
);

  logic               busy;
  logic [COORD_W-1:0] bi;
  logic [COORD_W-1:0] bj;
  logic [COORD_W-1:0] bi_m1;
  logic [COORD_W-1:0] bj_m1;
  logic               s1_valid;
  logic               s1_zero;
  logic               s1_last;
  logic [PFX_AW-1:0]  s1_addr;
  logic [DATA_W-1:0]  row_sum;
  logic [DATA_W-1:0]  row_sum_next;

  assign bi_m1 = (bi == '0) ? '0 : bi - 1'b1;
  assign bj_m1 = (bj == '0) ? '0 : bj - 1'b1;
  assign cell_rd_addr = cell_addr(bi_m1, bj_m1);
  assign pfx_rd_addr  = pfx_addr(bi_m1, bj);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      bi       <= '0;
      bj       <= '0;
    end else begin
      s1_valid <= busy;
      s1_last  <= busy && (bi == grid_height) && (bj == grid_width);
      if (start) begin
        busy <= 1'b1;
        bi   <= '0;
        bj   <= '0;
      end else if (busy) begin
        if (bj == grid_width) begin
          bj <= '0;
          if (bi == grid_height) begin
            busy <= 1'b0;
          end else begin
            bi <= bi + 1'b1;
          end
        end else begin
          bj <= bj + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_zero <= (bi == '0) || (bj == '0);
    s1_addr <= pfx_addr(bi, bj);
    if (s1_valid) begin
      row_sum <= row_sum_next;
    end
  end

  assign row_sum_next = s1_zero ? '0 : row_sum + cell_rd_data;

  always_comb begin
    pfx_wr.en   = s1_valid;
    pfx_wr.addr = s1_addr;
    pfx_wr.data = s1_zero ? '0 : pfx_rd_data + row_sum_next;
  end

  assign done = s1_valid && s1_last;

endmodule
`default_nettype wire

FILE: hw/rtl/summed_area_table.sv
// Top level of the summed-area table: item control, configuration registers,
// cell and prefix memories. Uses sat_pkg, sat_ram and sat_build.
//
// Usage:
//   s_* carries one operation item per handshake (add, build, query).
//   m_* returns exactly one result item per input item, in order.
//   cfg_* writes grid_height (index 0) and grid_width (index 1); cfg_ready
//   is always high, out-of-range values and unknown indexes are dropped.
// Sequence from accept to m_tvalid with the receiver ready: an add passes
//   ST_ADD, a query ST_Q1 to ST_Q4, and a build waits in ST_BUILD while all
//   (grid_height+1)*(grid_width+1) prefix entries are written by the single
//   prefix memory port, one entry per cycle; then ST_DONE, where an error or
//   unused opcode goes at once. One item is in flight at a time; s_tready
//   rises again as its result enters the output register, and not before.
// Reset: a clearing pass of PFX_DEPTH addresses (4225 at 64x64) zeroes both
//   memories; s_tready stays low during the pass, configuration is taken.
// Stall: a result waits in the output register while m_tready is low; the
//   next item is accepted and processed, and holds in place until the
//   register frees up.
`default_nettype none
module summed_area_table
  import sat_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // opcode[1:0], row[8:2], col[15:9], row_end[22:16], col_end[29:23],
  // value[61:30], zero[63:62]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // rect_sum[31:0], status[32], zero[39:33]
  output logic      [OUT_TDATA_W-1:0] m_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IW-1:0]      cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_BUILD = 4'd3;
  localparam logic [3:0] ST_Q1    = 4'd4;
  localparam logic [3:0] ST_Q2    = 4'd5;
  localparam logic [3:0] ST_Q3    = 4'd6;
  localparam logic [3:0] ST_Q4    = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]          state;
  logic [PFX_AW-1:0]   clr;
  logic [DIM_W-1:0]    grid_height;
  logic [DIM_W-1:0]    grid_width;

  logic [OP_W-1:0]     in_op;
  logic [COORD_W-1:0]  in_row;
  logic [COORD_W-1:0]  in_col;
  logic [COORD_W-1:0]  in_row_end;
  logic [COORD_W-1:0]  in_col_end;
  logic [DATA_W-1:0]   in_value;
  logic                accept;
  logic                add_ok;
  logic                query_ok;

  logic [COORD_W-1:0]  q_row;
  logic [COORD_W-1:0]  q_col;
  logic [COORD_W-1:0]  q_row_end;
  logic [COORD_W-1:0]  q_col_end;
  logic [CELL_AW-1:0]  add_addr;
  logic [DATA_W-1:0]   add_value;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   res_sum;
  logic                res_status;

  logic                cell_we;
  logic [CELL_AW-1:0]  cell_waddr;
  logic [DATA_W-1:0]   cell_wdata;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [DATA_W-1:0]   cell_rdata;
  logic                pfx_we;
  logic [PFX_AW-1:0]   pfx_waddr;
  logic [DATA_W-1:0]   pfx_wdata;
  logic [PFX_AW-1:0]   pfx_raddr;
  logic [DATA_W-1:0]   pfx_rdata;

  logic                build_start;
  logic [CELL_AW-1:0]  build_cell_raddr;
  logic [PFX_AW-1:0]   build_pfx_raddr;
  pfx_wr_t             build_wr;
  logic                build_done;
  logic                out_free;

  assign in_op      = s_tdata[1:0];
  assign in_row     = s_tdata[8:2];
  assign in_col     = s_tdata[15:9];
  assign in_row_end = s_tdata[22:16];
  assign in_col_end = s_tdata[29:23];
  assign in_value   = s_tdata[61:30];

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign cfg_ready   = 1'b1;
  assign out_free    = !m_tvalid || m_tready;
  assign build_start = accept && (in_op == OP_BUILD);

  assign add_ok   = (in_row < grid_height) && (in_col < grid_width);
  assign query_ok = (in_row <= in_row_end) && (in_col <= in_col_end) &&
                    (in_row_end <= grid_height) && (in_col_end <= grid_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= DIM_W'(DIM_RESET_H);
      grid_width  <= DIM_W'(DIM_RESET_W);
    end else if (cfg_valid && cfg_ready) begin
      if ((cfg_index == REG_GRID_HEIGHT) && (cfg_data != '0) &&
          (int'(cfg_data) <= MAX_ROWS)) begin
        grid_height <= cfg_data;
      end
      if ((cfg_index == REG_GRID_WIDTH) && (cfg_data != '0) &&
          (int'(cfg_data) <= MAX_COLS)) begin
        grid_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == PFX_DEPTH - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            priority if ((in_op == OP_ADD) && add_ok) begin
              state <= ST_ADD;
            end else if (in_op == OP_BUILD) begin
              state <= ST_BUILD;
            end else if ((in_op == OP_QUERY) && query_ok) begin
              state <= ST_Q1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_ADD:   state <= ST_DONE;
        ST_BUILD: begin
          if (build_done) begin
            state <= ST_DONE;
          end
        end
        ST_Q1:    state <= ST_Q2;
        ST_Q2:    state <= ST_Q3;
        ST_Q3:    state <= ST_Q4;
        ST_Q4:    state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_row      <= in_row;
      q_col      <= in_col;
      q_row_end  <= in_row_end;
      q_col_end  <= in_col_end;
      add_addr   <= cell_addr(in_row, in_col);
      add_value  <= in_value;
      res_sum    <= '0;
      res_status <= !(((in_op == OP_ADD) && add_ok) || (in_op == OP_BUILD) ||
                      ((in_op == OP_QUERY) && query_ok));
    end
    unique case (state)
      ST_Q1:   acc <= pfx_rdata;
      ST_Q2:   acc <= acc - pfx_rdata;
      ST_Q3:   acc <= acc - pfx_rdata;
      ST_Q4:   res_sum <= acc + pfx_rdata;
      default: acc <= acc;
    endcase
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {{(OUT_TDATA_W - DATA_W - 1){1'b0}}, res_status, res_sum};
    end
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = add_addr;
    cell_wdata = cell_rdata + add_value;
    if (state == ST_CLEAR) begin
      cell_we    = int'(clr) < CELL_DEPTH;
      cell_waddr = clr[CELL_AW-1:0];
      cell_wdata = '0;
    end else if (state == ST_ADD) begin
      cell_we = 1'b1;
    end
    cell_raddr = (state == ST_BUILD) ? build_cell_raddr : cell_addr(in_row, in_col);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      pfx_we    = 1'b1;
      pfx_waddr = clr;
      pfx_wdata = '0;
    end else begin
      pfx_we    = build_wr.en;
      pfx_waddr = build_wr.addr;
      pfx_wdata = build_wr.data;
    end
    unique case (state)
      ST_BUILD: pfx_raddr = build_pfx_raddr;
      ST_Q1:    pfx_raddr = pfx_addr(q_row, q_col_end);
      ST_Q2:    pfx_raddr = pfx_addr(q_row_end, q_col);
      ST_Q3:    pfx_raddr = pfx_addr(q_row, q_col);
      default:  pfx_raddr = pfx_addr(in_row_end, in_col_end);
    endcase
  end

  sat_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  sat_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PFX_DEPTH)
  ) u_pfx_ram (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (pfx_waddr),
    .wdata (pfx_wdata),
    .raddr (pfx_raddr),
    .rdata (pfx_rdata)
  );

  sat_build u_build (
    .clk          (clk),
    .rst          (rst),
    .start        (build_start),
    .grid_height  (grid_height),
    .grid_width   (grid_width),
    .cell_rd_data (cell_rdata),
    .pfx_rd_data  (pfx_rdata),
    .cell_rd_addr (build_cell_raddr),
    .pfx_rd_addr  (build_pfx_raddr),
    .pfx_wr       (build_wr),
    .done         (build_done)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/sat_checker.sv
// Port-level checks for summed_area_table, attached by the bind below.
// Uses sat_pkg.
`default_nettype none
module sat_checker
  import sat_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '0)
    else $error("error result carries a nonzero sum");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block active right after reset");

endmodule

bind summed_area_table sat_checker u_sat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire

FILE: bench/sat_tb_pkg.sv
`timescale 1ns / 1ps
// Item types and the in-order scoreboard for the summed-area table bench.
// Keeps its own grid, prefix table and grid size. Depends on sat_pkg.
package sat_tb_pkg;
  import sat_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row_end;
    logic [COORD_W-1:0] col_end;
    logic [DATA_W-1:0]  value;
  } sat_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rect_sum;
    logic              status;
  } sat_answer_t;

  class rect_sum_scoreboard;
    logic [DATA_W-1:0] cells [CELL_DEPTH];
    logic [DATA_W-1:0] prefix [PFX_DEPTH];
    int unsigned       height;
    int unsigned       width;
    sat_answer_t       expected_sums[$];
    int unsigned       ops_seen [4];
    int unsigned       rejected;
    int unsigned       checked;
    int unsigned       errors;

    function new();
      foreach (cells[k]) cells[k] = '0;
      foreach (prefix[k]) prefix[k] = '0;
      foreach (ops_seen[k]) ops_seen[k] = 0;
      height   = DIM_RESET_H;
      width    = DIM_RESET_W;
      rejected = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    function void note_register(input logic [CFG_IW-1:0] index,
                                input logic [DIM_W-1:0] data);
      if (index == REG_GRID_HEIGHT) begin
        if (data >= 1 && data <= MAX_ROWS) height = 32'(data);
      end else if (index == REG_GRID_WIDTH) begin
        if (data >= 1 && data <= MAX_COLS) width = 32'(data);
      end
    endfunction

    function void rebuild_prefix();
      for (int j = 0; j <= width; j++) prefix[j] = '0;
      for (int i = 1; i <= height; i++) begin
        prefix[i*PSTRIDE] = '0;
        for (int j = 1; j <= width; j++) begin
          prefix[i*PSTRIDE + j] = cells[(i-1)*MAX_COLS + j - 1]
                                + prefix[(i-1)*PSTRIDE + j]
                                + prefix[i*PSTRIDE + j - 1]
                                - prefix[(i-1)*PSTRIDE + j - 1];
        end
      end
    endfunction

    function void note_item(input sat_item_t item);
      sat_answer_t ans;
      int unsigned r0, c0, r1, c1;
      ans = '0;
      r0  = 32'(item.row);
      c0  = 32'(item.col);
      r1  = 32'(item.row_end);
      c1  = 32'(item.col_end);
      ops_seen[item.opcode]++;
      case (item.opcode)
        OP_ADD: begin
          if (r0 < height && c0 < width) cells[r0*MAX_COLS + c0] += item.value;
          else ans.status = 1'b1;
        end
        OP_BUILD: rebuild_prefix();
        OP_QUERY: begin
          if (r0 <= r1 && c0 <= c1 && r1 <= height && c1 <= width) begin
            ans.rect_sum = prefix[r1*PSTRIDE + c1] - prefix[r0*PSTRIDE + c1]
                         - prefix[r1*PSTRIDE + c0] + prefix[r0*PSTRIDE + c0];
          end else begin
            ans.status = 1'b1;
          end
        end
        default: ans.status = 1'b1;
      endcase
      if (ans.status) rejected++;
      expected_sums.push_back(ans);
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
      sat_answer_t       want;
      logic [DATA_W-1:0] got_sum;
      logic              got_status;
      got_sum    = tdata[DATA_W-1:0];
      got_status = tdata[DATA_W];
      if (expected_sums.size() == 0) begin
        $error("result with no item outstanding: rect_sum %0d status %0b",
               $signed(got_sum), got_status);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      checked++;
      if (got_sum !== want.rect_sum) begin
        $error("rect_sum: expected %0d, actual %0d", $signed(want.rect_sum),
               $signed(got_sum));
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, got_status);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_summed_area_table.sv
`timescale 1ns / 1ps
// Top of the summed-area table bench: clock, reset, stream drivers, config
// writes and the result monitor. Depends on sat_pkg, sat_tb_pkg and the RTL.
module tb_summed_area_table;
  import sat_pkg::*;
  import sat_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int          NUM_PHASES      = 12;
  localparam int          ITEMS_PER_PHASE = 135;
  localparam int unsigned LONG_HOLD       = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IW-1:0]      cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;

  rect_sum_scoreboard sb = new();
  int unsigned        hold_requests = 0;

  summed_area_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles,
             sb.expected_sums.size());
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin : receiver
    int unsigned mode, mode_left, hold_left, holds_seen;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 7) == 0);
          default: m_tready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic sat_item_t item_of(input logic [OP_W-1:0] opcode,
                                        input int unsigned r, input int unsigned c,
                                        input int unsigned re, input int unsigned ce,
                                        input logic [DATA_W-1:0] value);
    sat_item_t item;
    item.opcode  = opcode;
    item.row     = COORD_W'(r);
    item.col     = COORD_W'(c);
    item.row_end = COORD_W'(re);
    item.col_end = COORD_W'(ce);
    item.value   = value;
    return item;
  endfunction

  function automatic sat_item_t random_item(input int unsigned h, input int unsigned w,
                                            input bit allow_build);
    sat_item_t   item;
    int unsigned pick;
    item.opcode  = OP_ADD;
    item.row     = COORD_W'($urandom_range(0, 127));
    item.col     = COORD_W'($urandom_range(0, 127));
    item.row_end = COORD_W'($urandom_range(0, 127));
    item.col_end = COORD_W'($urandom_range(0, 127));
    item.value   = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      item.opcode = OP_W'($urandom_range(0, 3));
      if (item.opcode == OP_BUILD && !allow_build) item.opcode = OP_UNUSED;
    end else if (pick < 14 && allow_build) begin
      item.opcode = OP_BUILD;
    end else if (pick < 55) begin
      item.opcode = OP_ADD;
      item.row    = COORD_W'($urandom_range(0, h - 1));
      item.col    = COORD_W'($urandom_range(0, w - 1));
      if (pick == 50) item.row = COORD_W'(h);
      if (pick == 51) item.col = COORD_W'(w);
    end else begin
      item.opcode  = OP_QUERY;
      item.row     = COORD_W'($urandom_range(0, h));
      item.row_end = COORD_W'($urandom_range(item.row, h));
      item.col     = COORD_W'($urandom_range(0, w));
      item.col_end = COORD_W'($urandom_range(item.col, w));
      if (pick >= 92) begin
        case (pick % 4)
          0: item.row = item.row_end + 1'b1;
          1: item.col = item.col_end + 1'b1;
          2: item.row_end = COORD_W'($urandom_range(h + 1, 127));
          default: item.col_end = COORD_W'($urandom_range(w + 1, 127));
        endcase
      end
    end
    return item;
  endfunction

  task automatic send_item(input sat_item_t item);
    @(negedge clk);
    s_tdata  = {2'b00, item.value, item.col_end, item.row_end, item.col, item.row,
                item.opcode};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_item(item);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = {$urandom(), $urandom()};
    end
  endtask

  task automatic drain_results(input int unsigned settle);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_sums.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IW-1:0] index,
                                input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    sat_item_t   directed[$];
    sat_item_t   item;
    int unsigned h, w, builds, build_cap, burst_left;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset size is 64x64; the prefix table is still all zero here
    directed.push_back(item_of(OP_QUERY, 0, 0, 64, 64, 32'h1234_5678));
    directed.push_back(item_of(OP_ADD, 0, 0, 0, 0, 32'h7FFF_FFFF));
    directed.push_back(item_of(OP_ADD, 63, 63, 0, 0, 32'h8000_0000));
    directed.push_back(item_of(OP_ADD, 0, 63, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(item_of(OP_ADD, 63, 0, 0, 0, 32'h0000_0001));
    directed.push_back(item_of(OP_ADD, 0, 0, 0, 0, 32'h0000_0001));
    directed.push_back(item_of(OP_ADD, 64, 0, 0, 0, 32'h0000_0005));
    directed.push_back(item_of(OP_ADD, 0, 64, 0, 0, 32'h0000_0005));
    directed.push_back(item_of(OP_ADD, 127, 127, 127, 127, 32'hFFFF_FFFF));
    directed.push_back(item_of(OP_UNUSED, 127, 127, 127, 127, 32'hFFFF_FFFF));
    directed.push_back(item_of(OP_QUERY, 0, 0, 64, 64, 32'h0));
    directed.push_back(item_of(OP_BUILD, 0, 0, 0, 0, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 0, 64, 64, 32'h0));
    directed.push_back(item_of(OP_QUERY, 63, 63, 64, 64, 32'h0));
    directed.push_back(item_of(OP_QUERY, 5, 5, 5, 9, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 7, 64, 7, 32'h0));
    directed.push_back(item_of(OP_QUERY, 10, 0, 9, 64, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 10, 64, 9, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 0, 65, 64, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 0, 64, 127, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 0, 0, 0, 32'h0));
    directed.push_back(item_of(OP_QUERY, 1, 1, 63, 63, 32'h0));
    directed.push_back(item_of(OP_QUERY, 0, 0, 1, 1, 32'h0));
    foreach (directed[k]) send_item(directed[k]);

    burst_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin h = 1;  w = 1;  end
        1: begin h = 64; w = 64; end
        2: begin h = 64; w = 1;  end
        3: begin h = 1;  w = 64; end
        4: begin h = $urandom_range(1, 64); w = $urandom_range(1, 64); end
        NUM_PHASES - 1: begin h = 64; w = 64; end
        default: begin h = $urandom_range(1, 12); w = $urandom_range(1, 12); end
      endcase
      drain_results(10);
      if (ph == 0) begin
        write_register(8'hFF, 7'h7F);
        write_register(REG_GRID_WIDTH, 7'd0);
        write_register(REG_GRID_HEIGHT, 7'h7F);
      end else if ($urandom_range(0, 2) == 0) begin
        write_register(CFG_IW'($urandom_range(2, 255)), DIM_W'($urandom_range(0, 127)));
        write_register(CFG_IW'($urandom_range(0, 1)),
                       DIM_W'(($urandom_range(0, 1) == 0) ? 0
                                                          : $urandom_range(65, 127)));
      end
      write_register(REG_GRID_HEIGHT, DIM_W'(h));
      write_register(REG_GRID_WIDTH, DIM_W'(w));

      builds    = 0;
      build_cap = (h * w <= 256) ? 1000 : 2;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph % 6 == 1 && k == ITEMS_PER_PHASE / 3) hold_requests++;
        if (ph % 6 == 1 && k == 2 * ITEMS_PER_PHASE / 3) drain_results(0);
        if (burst_left == 0) begin
          idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        end
        burst_left--;
        item = random_item(h, w, builds < build_cap);
        if (item.opcode == OP_BUILD) builds++;
        send_item(item);
      end
    end

    drain_results(20);
    $display("covered %0d adds, %0d builds, %0d queries, %0d unused opcodes",
             sb.ops_seen[OP_ADD], sb.ops_seen[OP_BUILD], sb.ops_seen[OP_QUERY],
             sb.ops_seen[OP_UNUSED]);
    $display("%0d results checked across %0d grid sizes, %0d rejected, %0d mismatches",
             sb.checked, NUM_PHASES + 1, sb.rejected, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
